/* sv/sglf_pkg.sv */
// shared types and constants for the spectrum gap linear fill block
// no dependencies
package sglf_pkg;

  localparam int MAX_GAP_DEF = 63;

  // status codes carried on each result word
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_OVF     = 2'd1;
  localparam logic [1:0] STAT_NOVALID = 2'd2;

  typedef enum logic [1:0] {
    SEL_HOLD,
    SEL_LINE,
    SEL_SELF
  } emit_sel_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       store;
    logic       clr_idx;
    logic       inc_idx;
    logic       clr_cnt;
    logic       mul;
    logic       absd;
    logic       div_step;
    logic       emit;
    emit_sel_t  emit_sel;
    logic [1:0] out_status;
    logic       out_run_last;
    logic       out_end;
    logic       upd_prev;
    logic       clr_state;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_gap;
    logic is_last;
    logic cnt_full;
    logic cnt_zero;
    logic idx_last;
    logic line_needed;
    logic div_last;
    logic out_free;
    logic have_valid;
  } sts_t;

endpackage

/* sv/sglf_ram.sv */
// generic simple dual port ram with registered read
// no dependencies
module sglf_ram #(
  parameter int W = 32,
  parameter int D = 63
) (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] wr_addr,
  input  logic [W-1:0]                    wr_data,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] rd_addr,
  output logic [W-1:0]                    rd_data
);

  logic [W-1:0] mem [D];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* sv/sglf_ctrl.sv */
// controller state machine for the gap fill block
// depends on sglf_pkg
module sglf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  sglf_pkg::sts_t sts,
  output sglf_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_STORE,
    S_FL_RD,
    S_FL_EMIT,
    S_IP_RD,
    S_IP_MUL,
    S_IP_ABS,
    S_IP_DIV,
    S_IP_EMIT,
    S_SELF_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   ovf_r, ovf_nxt;

  assign in_stall = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    ovf_nxt   = ovf_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.clr_idx = 1'b1;
        if (sts.is_gap) begin
          if (sts.cnt_full) begin
            ovf_nxt   = 1'b1;
            state_nxt = S_FL_RD;
          end else begin
            state_nxt = S_STORE;
          end
        end else if (sts.cnt_zero) begin
          state_nxt = S_SELF_EMIT;
        end else begin
          state_nxt = S_IP_RD;
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        if (sts.is_last) begin
          cmd.clr_idx = 1'b1;
          ovf_nxt     = 1'b0;
          state_nxt   = S_FL_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_FL_RD: state_nxt = S_FL_EMIT;
      S_FL_EMIT: begin
        if (sts.out_free) begin
          cmd.emit         = 1'b1;
          cmd.emit_sel     = sglf_pkg::SEL_HOLD;
          cmd.out_status   = ovf_r ? sglf_pkg::STAT_OVF :
                             (sts.have_valid ? sglf_pkg::STAT_OK : sglf_pkg::STAT_NOVALID);
          // an overflow flush ends the word run unless a trailing flush follows
          cmd.out_run_last = sts.idx_last && (!ovf_r || !sts.is_last);
          cmd.out_end      = !ovf_r && sts.idx_last;
          if (sts.idx_last) begin
            cmd.clr_cnt = 1'b1;
            if (ovf_r) begin
              ovf_nxt   = 1'b0;
              state_nxt = S_STORE;
            end else begin
              cmd.clr_state = 1'b1;
              state_nxt     = S_IDLE;
            end
          end else begin
            cmd.inc_idx = 1'b1;
            state_nxt   = S_FL_RD;
          end
        end
      end
      S_IP_RD: state_nxt = sts.line_needed ? S_IP_MUL : S_IP_EMIT;
      S_IP_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_IP_ABS;
      end
      S_IP_ABS: begin
        cmd.absd  = 1'b1;
        state_nxt = S_IP_DIV;
      end
      S_IP_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_IP_EMIT;
      end
      S_IP_EMIT: begin
        if (sts.out_free) begin
          cmd.emit       = 1'b1;
          cmd.emit_sel   = sglf_pkg::SEL_LINE;
          cmd.out_status = sglf_pkg::STAT_OK;
          if (sts.idx_last) begin
            cmd.clr_cnt = 1'b1;
            state_nxt   = S_SELF_EMIT;
          end else begin
            cmd.inc_idx = 1'b1;
            state_nxt   = S_IP_RD;
          end
        end
      end
      S_SELF_EMIT: begin
        if (sts.out_free) begin
          cmd.emit         = 1'b1;
          cmd.emit_sel     = sglf_pkg::SEL_SELF;
          cmd.out_status   = sglf_pkg::STAT_OK;
          cmd.out_run_last = 1'b1;
          cmd.out_end      = sts.is_last;
          cmd.upd_prev     = 1'b1;
          cmd.clr_state    = sts.is_last;
          state_nxt        = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

/* sv/sglf_datapath.sv */
// datapath: sample registers, gap buffer, multiplier, serial divider, result word
// depends on sglf_pkg and sglf_ram
module sglf_datapath #(
  parameter int MAX_GAP = sglf_pkg::MAX_GAP_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [31:0]        in_wavelength,
  input  logic signed [31:0] in_flux,
  input  logic               in_last_sample,
  input  sglf_pkg::cmd_t     cmd,
  output sglf_pkg::sts_t     sts,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_wavelength,
  output logic signed [31:0] out_flux,
  output logic               out_was_filled,
  output logic               out_run_last,
  output logic               out_spectrum_end,
  output logic [1:0]         out_status
);

  localparam int AW = (MAX_GAP > 1) ? $clog2(MAX_GAP) : 1;
  localparam int CW = $clog2(MAX_GAP + 1);
  localparam logic [63:0] QCLAMP = 64'd1 << 40;

  logic [31:0]   wl_r, fx_r, prev_wl_r, prev_fx_r;
  logic          last_r, hv_r;
  logic [CW-1:0] cnt_r;
  logic [AW-1:0] idx_r;
  logic [31:0]   rd_data;

  logic signed [63:0] prod_r;
  logic [63:0]        num_r;
  logic [31:0]        den_mag_r, rem_r;
  logic               neg_r;
  logic [5:0]         div_cnt_r;
  logic               out_valid_r;

  // gap wavelength buffer
  sglf_ram #(.W(32), .D(MAX_GAP)) u_gap_ram (
    .clk     (clk),
    .wr_en   (cmd.store),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data (wl_r),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  // line terms
  logic signed [32:0] diff, off, den;
  logic signed [65:0] prod_full;
  assign diff = $signed({fx_r[31], fx_r}) - $signed({prev_fx_r[31], prev_fx_r});
  assign off  = $signed({1'b0, rd_data}) - $signed({1'b0, prev_wl_r});
  assign den  = $signed({1'b0, wl_r}) - $signed({1'b0, prev_wl_r});
  assign prod_full = diff * off;

  // one restoring divide step
  logic [32:0] rem_sh, rem_sub;
  logic        ge;
  assign rem_sh  = {rem_r, num_r[63]};
  assign rem_sub = rem_sh - {1'b0, den_mag_r};
  assign ge      = (rem_sh >= {1'b0, den_mag_r});

  // quotient clamp, sign and saturating add
  logic [40:0]        qm;
  logic signed [42:0] qs, lsum;
  logic [31:0]        line_fx;
  always_comb begin
    qm   = (num_r > QCLAMP) ? QCLAMP[40:0] : num_r[40:0];
    qs   = neg_r ? -$signed({2'b00, qm}) : $signed({2'b00, qm});
    lsum = $signed({{11{prev_fx_r[31]}}, prev_fx_r}) + qs;
    if (lsum > 43'sd2147483647)        line_fx = 32'h7FFF_FFFF;
    else if (lsum < -43'sd2147483648)  line_fx = 32'h8000_0000;
    else                               line_fx = lsum[31:0];
  end

  // result word selection
  logic [31:0] sel_wl, sel_fx;
  logic        sel_filled;
  always_comb begin
    unique case (cmd.emit_sel)
      sglf_pkg::SEL_HOLD: begin
        sel_wl = rd_data; sel_fx = hv_r ? prev_fx_r : 32'd0; sel_filled = 1'b1;
      end
      sglf_pkg::SEL_LINE: begin
        sel_wl     = rd_data;
        sel_fx     = !hv_r ? fx_r : ((den == 33'sd0) ? prev_fx_r : line_fx);
        sel_filled = 1'b1;
      end
      sglf_pkg::SEL_SELF: begin
        sel_wl = wl_r; sel_fx = fx_r; sel_filled = 1'b0;
      end
      default: begin
        sel_wl = wl_r; sel_fx = fx_r; sel_filled = 1'b0;
      end
    endcase
  end

  // status to the controller
  assign sts.is_gap      = fx_r[31];
  assign sts.is_last     = last_r;
  assign sts.cnt_full    = (cnt_r == CW'(MAX_GAP));
  assign sts.cnt_zero    = (cnt_r == '0);
  assign sts.idx_last    = ((CW'(idx_r) + CW'(1)) == cnt_r);
  assign sts.line_needed = hv_r && (den != 33'sd0);
  assign sts.div_last    = (div_cnt_r == 6'd63);
  assign sts.out_free    = !out_valid_r || !out_stall;
  assign sts.have_valid  = hv_r;

  assign out_valid = out_valid_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r        <= 1'b0;
      cnt_r       <= '0;
      idx_r       <= '0;
      prev_wl_r   <= '0;
      prev_fx_r   <= '0;
      out_valid_r <= 1'b0;
      div_cnt_r   <= '0;
    end else begin
      if (cmd.clr_idx)      idx_r <= '0;
      else if (cmd.inc_idx) idx_r <= idx_r + AW'(1);
      if (cmd.store)                        cnt_r <= cnt_r + CW'(1);
      else if (cmd.clr_cnt || cmd.clr_state) cnt_r <= '0;
      if (cmd.absd)          div_cnt_r <= '0;
      else if (cmd.div_step) div_cnt_r <= div_cnt_r + 6'd1;
      if (cmd.clr_state) begin
        hv_r      <= 1'b0;
        prev_wl_r <= '0;
        prev_fx_r <= '0;
      end else if (cmd.upd_prev) begin
        hv_r      <= 1'b1;
        prev_wl_r <= wl_r;
        prev_fx_r <= fx_r;
      end
      if (cmd.emit)          out_valid_r <= 1'b1;
      else if (!out_stall)   out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wl_r   <= in_wavelength;
      fx_r   <= in_flux;
      last_r <= in_last_sample;
    end
    if (cmd.mul) prod_r <= prod_full[63:0];
    if (cmd.absd) begin
      num_r     <= prod_r[63] ? 64'(-prod_r) : 64'(prod_r);
      neg_r     <= prod_r[63] ^ den[32];
      den_mag_r <= den[32] ? 32'(-den) : den[31:0];
      rem_r     <= '0;
    end else if (cmd.div_step) begin
      rem_r <= ge ? rem_sub[31:0] : rem_sh[31:0];
      num_r <= {num_r[62:0], ge};
    end
    if (cmd.emit) begin
      out_wavelength   <= sel_wl;
      out_flux         <= sel_fx;
      out_was_filled   <= sel_filled;
      out_run_last     <= cmd.out_run_last;
      out_spectrum_end <= cmd.out_end;
      out_status       <= cmd.out_status;
    end
  end

  // buffer never written past its depth
  a_store_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |-> (cnt_r < CW'(MAX_GAP)))
    else $error("gap buffer written while full");

  // a word is only loaded when the output register can take it
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result word overwritten");

  // spectrum end only on the last word of an input
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_spectrum_end) |-> out_run_last)
    else $error("spectrum end without run last");

  // a divide step always follows the setup of the divider operands
  a_div_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.absd |=> cmd.div_step)
    else $error("divider not started after setup");

endmodule

/* sv/spectrum_gap_linear_fill_top.sv */
// Spectrum gap linear fill. Samples come in order; a negative flux marks a gap whose
// wavelength is buffered (up to MAX_GAP entries). A valid sample releases the buffered
// gap words first, each with a flux on the line to its neighbors (the valid sample's
// flux when no earlier valid sample exists), then itself. Gap words flushed on overflow
// or at spectrum end hold the last valid flux, or zero if none. Each interpolated flux
// is formed by a bit-serial 64-step divider. Output backpressure adds wait cycles.
// depends on sglf_pkg, sglf_ctrl, sglf_datapath
module spectrum_gap_linear_fill_top #(
  parameter int MAX_GAP = sglf_pkg::MAX_GAP_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        in_wavelength,
  input  logic signed [31:0] in_flux,
  input  logic               in_last_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_wavelength,
  output logic signed [31:0] out_flux,
  output logic               out_was_filled,
  output logic               out_run_last,
  output logic               out_spectrum_end,
  output logic [1:0]         out_status
);

  sglf_pkg::cmd_t cmd;
  sglf_pkg::sts_t sts;

  // sequencer
  sglf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // arithmetic and storage
  sglf_datapath #(.MAX_GAP(MAX_GAP)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_wavelength    (in_wavelength),
    .in_flux          (in_flux),
    .in_last_sample   (in_last_sample),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_wavelength   (out_wavelength),
    .out_flux         (out_flux),
    .out_was_filled   (out_was_filled),
    .out_run_last     (out_run_last),
    .out_spectrum_end (out_spectrum_end),
    .out_status       (out_status)
  );

endmodule
